// ===== rtl/core/phfu_pkg.sv =====
// Package with opcodes, action codes and stage records of the hazard and forwarding unit.
package phfu_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'b000000;
  localparam logic [5:0] OP_LW      = 6'b100011;
  localparam logic [5:0] OP_SW      = 6'b101011;
  localparam logic [5:0] OP_BEQ     = 6'b000100;
  localparam logic [5:0] OP_J       = 6'b000010;
  localparam logic [5:0] OP_JAL     = 6'b000011;
  localparam logic [5:0] OP_LUI     = 6'b001111;

  localparam logic [5:0] FUNCT_SLL  = 6'b000000;
  localparam logic [5:0] FUNCT_SRL  = 6'b000010;
  localparam logic [5:0] FUNCT_JR   = 6'b001000;

  localparam logic [31:0] NOOP_WORD = 32'h0000_0000;

  localparam logic [1:0] SEL_REGFILE   = 2'd0;
  localparam logic [1:0] SEL_EXECUTE   = 2'd1;
  localparam logic [1:0] SEL_WRITEBACK = 2'd2;

  localparam logic [1:0] FETCH_HOLD   = 2'd0;
  localparam logic [1:0] FETCH_NEXT   = 2'd1;
  localparam logic [1:0] FETCH_BUBBLE = 2'd2;

  localparam logic [2:0] PC_HOLD     = 3'd0;
  localparam logic [2:0] PC_PLUS4    = 3'd1;
  localparam logic [2:0] PC_JUMP     = 3'd2;
  localparam logic [2:0] PC_REGISTER = 3'd3;
  localparam logic [2:0] PC_BRANCH   = 3'd4;

  typedef struct packed {
    logic       rd_rs;
    logic       rd_rt;
    logic [4:0] rs;
    logic [4:0] rt;
    logic       wr_en;
    logic [4:0] wreg;
    logic       ld;
    logic       beq;
    logic       jump;
    logic       jal;
    logic       jr;
  } dec_info_t;

  typedef struct packed {
    dec_info_t   dec;
    dec_info_t   exe;
    dec_info_t   mem;
    logic [25:0] target;
  } s1_t;

  typedef struct packed {
    logic        hazard;
    logic        bstall;
    logic        exe_beq;
    logic        fwd_e_rs;
    logic        fwd_m_rs;
    logic        fwd_e_rt;
    logic        fwd_m_rt;
    logic        jump;
    logic        jal;
    logic        jr;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [25:0] target;
  } s2_t;

  typedef struct packed {
    logic        load_use_stall;
    logic        branch_stall;
    logic [1:0]  first_source_select;
    logic [1:0]  second_source_select;
    logic [1:0]  fetch_action;
    logic [2:0]  pc_action;
    logic [27:0] jump_target;
    logic        link_write;
    logic [4:0]  jump_register_index;
    logic [4:0]  first_source_index;
    logic [4:0]  second_source_index;
  } res_t;

endpackage

// ===== rtl/core/phfu_if.sv =====
// Request and result channels of the hazard and forwarding unit.
interface phfu_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] decode_word;
  logic [31:0] execute_word;
  logic [31:0] memory_word;

  modport source (output valid, output decode_word, output execute_word,
                  output memory_word, input ready);
  modport sink (input valid, input decode_word, input execute_word,
                input memory_word, output ready);
endinterface

interface phfu_out_if;
  logic        valid;
  logic        ready;
  logic        load_use_stall;
  logic        branch_stall;
  logic [1:0]  first_source_select;
  logic [1:0]  second_source_select;
  logic [1:0]  fetch_action;
  logic [2:0]  pc_action;
  logic [27:0] jump_target;
  logic        link_write;
  logic [4:0]  jump_register_index;
  logic [4:0]  first_source_index;
  logic [4:0]  second_source_index;

  modport source (output valid, output load_use_stall, output branch_stall,
                  output first_source_select, output second_source_select,
                  output fetch_action, output pc_action, output jump_target,
                  output link_write, output jump_register_index,
                  output first_source_index, output second_source_index,
                  input ready);
  modport sink (input valid, input load_use_stall, input branch_stall,
                input first_source_select, input second_source_select,
                input fetch_action, input pc_action, input jump_target,
                input link_write, input jump_register_index,
                input first_source_index, input second_source_index,
                output ready);
endinterface

// ===== rtl/core/phfu_decode.sv =====
// Instruction classifier that gives the registers one word reads and writes.
module phfu_decode
  import phfu_pkg::*;
(
  input  logic [31:0] word,
  output dec_info_t   info
);

  logic [5:0] op;
  logic [5:0] funct;
  logic [4:0] rs;
  logic [4:0] rt;
  logic [4:0] rd;
  logic       reads_rs;
  logic       reads_rt;

  assign op    = word[31:26];
  assign funct = word[5:0];
  assign rs    = word[25:21];
  assign rt    = word[20:16];
  assign rd    = word[15:11];

  always_comb begin
    reads_rs   = 1'b0;
    reads_rt   = 1'b0;
    info.wr_en = 1'b0;
    info.wreg  = rt;
    info.ld    = 1'b0;
    info.beq   = 1'b0;
    info.jump  = 1'b0;
    info.jal   = 1'b0;
    info.jr    = 1'b0;
    case (op)
      OP_SPECIAL: begin
        if (funct == FUNCT_JR) begin
          info.jr  = 1'b1;
          reads_rs = 1'b1;
        end else if (word != NOOP_WORD) begin
          info.wr_en = 1'b1;
          info.wreg  = rd;
          reads_rt   = 1'b1;
          reads_rs   = !(funct == FUNCT_SLL || funct == FUNCT_SRL);
        end
      end
      OP_LW: begin
        reads_rs   = 1'b1;
        info.wr_en = 1'b1;
        info.ld    = 1'b1;
      end
      OP_SW: begin
        reads_rs = 1'b1;
        reads_rt = 1'b1;
      end
      OP_BEQ: begin
        reads_rs = 1'b1;
        reads_rt = 1'b1;
        info.beq = 1'b1;
      end
      OP_LUI: begin
        info.wr_en = 1'b1;
        info.ld    = 1'b1;
      end
      OP_J: begin
        info.jump = 1'b1;
      end
      OP_JAL: begin
        info.jump = 1'b1;
        info.jal  = 1'b1;
      end
      default: begin
        reads_rs = 1'b0;
      end
    endcase
    // A field counts as read when its register is in the read set at all.
    info.rd_rs = reads_rs || (reads_rt && rt == rs);
    info.rd_rt = reads_rt || (reads_rs && rs == rt);
    info.rs    = rs;
    info.rt    = rt;
  end

endmodule

// ===== rtl/core/pipeline_hazard_forward_unit_core.sv =====
// Top level of the pipeline hazard and forwarding unit.
// The unit takes one request per cycle while the output side is ready, each holding the decode,
// execute and memory stage instruction words, and presents the stall flags, operand forwarding
// selects, fetch and PC actions, jump target, link flag and register indices for it from the
// output register. The three register stages are decode, register compare and action select;
// each stage moves on when the one after it is empty or moving, so a stalled result waits in
// the output register while later requests close up into empty stages behind it, and the
// sustained rate is one request per cycle while the output side is ready.
module pipeline_hazard_forward_unit_core
  import phfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  phfu_in_if.sink     in_if,
  phfu_out_if.source  out_if
);

  logic  v1_r, v2_r, v3_r;
  logic  rdy1, rdy2, rdy3;
  s1_t   s1_r, s1_nxt;
  s2_t   s2_r, s2_nxt;
  res_t  s3_r, s3_nxt;

  assign rdy3 = !v3_r || out_if.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_if.ready = rdy1;

  phfu_decode u_dec_decode (.word(in_if.decode_word),  .info(s1_nxt.dec));
  phfu_decode u_dec_execute (.word(in_if.execute_word), .info(s1_nxt.exe));
  phfu_decode u_dec_memory (.word(in_if.memory_word),  .info(s1_nxt.mem));
  assign s1_nxt.target = in_if.decode_word[25:0];

  always_comb begin
    s2_nxt.hazard   = s1_r.exe.ld && s1_r.exe.wr_en &&
                      ((s1_r.dec.rd_rs && s1_r.dec.rs == s1_r.exe.wreg) ||
                       (s1_r.dec.rd_rt && s1_r.dec.rt == s1_r.exe.wreg));
    s2_nxt.bstall   = s1_r.dec.beq || s1_r.exe.beq;
    s2_nxt.exe_beq  = s1_r.exe.beq;
    s2_nxt.fwd_e_rs = s1_r.dec.rd_rs && s1_r.exe.wr_en && s1_r.exe.wreg == s1_r.dec.rs;
    s2_nxt.fwd_m_rs = s1_r.dec.rd_rs && s1_r.mem.wr_en && s1_r.mem.wreg == s1_r.dec.rs;
    s2_nxt.fwd_e_rt = s1_r.dec.rd_rt && s1_r.exe.wr_en && s1_r.exe.wreg == s1_r.dec.rt;
    s2_nxt.fwd_m_rt = s1_r.dec.rd_rt && s1_r.mem.wr_en && s1_r.mem.wreg == s1_r.dec.rt;
    s2_nxt.jump     = s1_r.dec.jump;
    s2_nxt.jal      = s1_r.dec.jal;
    s2_nxt.jr       = s1_r.dec.jr;
    s2_nxt.rs       = s1_r.dec.rs;
    s2_nxt.rt       = s1_r.dec.rt;
    s2_nxt.target   = s1_r.target;
  end

  always_comb begin
    s3_nxt.load_use_stall = s2_r.hazard;
    s3_nxt.branch_stall   = s2_r.bstall;
    s3_nxt.first_source_select  = SEL_REGFILE;
    s3_nxt.second_source_select = SEL_REGFILE;
    if (!s2_r.hazard) begin
      if (s2_r.fwd_e_rs) begin
        s3_nxt.first_source_select = SEL_EXECUTE;
      end else if (s2_r.fwd_m_rs) begin
        s3_nxt.first_source_select = SEL_WRITEBACK;
      end
      if (s2_r.fwd_e_rt) begin
        s3_nxt.second_source_select = SEL_EXECUTE;
      end else if (s2_r.fwd_m_rt) begin
        s3_nxt.second_source_select = SEL_WRITEBACK;
      end
    end
    if (s2_r.hazard) begin
      s3_nxt.fetch_action = FETCH_HOLD;
    end else if (s2_r.bstall || s2_r.jump || s2_r.jr) begin
      s3_nxt.fetch_action = FETCH_BUBBLE;
    end else begin
      s3_nxt.fetch_action = FETCH_NEXT;
    end
    if (s2_r.exe_beq) begin
      s3_nxt.pc_action = PC_BRANCH;
    end else if (s2_r.bstall || s2_r.hazard) begin
      s3_nxt.pc_action = PC_HOLD;
    end else if (s2_r.jump) begin
      s3_nxt.pc_action = PC_JUMP;
    end else if (s2_r.jr) begin
      s3_nxt.pc_action = PC_REGISTER;
    end else begin
      s3_nxt.pc_action = PC_PLUS4;
    end
    s3_nxt.jump_target         = {s2_r.target, 2'b00};
    s3_nxt.link_write          = s2_r.jal && !s2_r.bstall && !s2_r.hazard;
    s3_nxt.jump_register_index = s2_r.rs;
    s3_nxt.first_source_index  = s2_r.rs;
    s3_nxt.second_source_index = s2_r.rt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_if.valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_r <= s1_nxt;
    end
    if (rdy2) begin
      s2_r <= s2_nxt;
    end
    if (rdy3) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_if.valid                = v3_r;
  assign out_if.load_use_stall       = s3_r.load_use_stall;
  assign out_if.branch_stall         = s3_r.branch_stall;
  assign out_if.first_source_select  = s3_r.first_source_select;
  assign out_if.second_source_select = s3_r.second_source_select;
  assign out_if.fetch_action         = s3_r.fetch_action;
  assign out_if.pc_action            = s3_r.pc_action;
  assign out_if.jump_target          = s3_r.jump_target;
  assign out_if.link_write           = s3_r.link_write;
  assign out_if.jump_register_index  = s3_r.jump_register_index;
  assign out_if.first_source_index   = s3_r.first_source_index;
  assign out_if.second_source_index  = s3_r.second_source_index;

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> v1_r)
    else $error("accepted request did not enter the first stage");

  a_stall_no_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && s3_r.load_use_stall |->
      s3_r.first_source_select == SEL_REGFILE && s3_r.second_source_select == SEL_REGFILE)
    else $error("forwarding select set during load-use stall");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && s3_r.load_use_stall |-> s3_r.fetch_action == FETCH_HOLD)
    else $error("fetch not held during load-use stall");

  a_link_jump: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && s3_r.link_write |-> s3_r.pc_action == PC_JUMP)
    else $error("link write without jump target");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out_if.ready |=> v3_r && $stable(s3_r))
    else $error("stalled result register changed");

endmodule

// ===== dv/tb_pipeline_hazard_forward_unit_core.sv =====
// Self-checking testbench of the hazard and forwarding unit with directed and random requests.
module tb_pipeline_hazard_forward_unit_core;
  import phfu_pkg::*;

  localparam logic [5:0] FUNCT_ADD = 6'b100000;
  localparam logic [5:0] OP_UNUSED = 6'b111110;
  localparam int IDLE_PCT [4] = '{0, 67, 0, 36};
  localparam int STALL_PCT [4] = '{0, 0, 67, 36};
  localparam int RANDOM_PER_PHASE = 270;
  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic [31:0] dec_w;
    logic [31:0] exe_w;
    logic [31:0] mem_w;
    bit          typed;
    res_t        want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   mismatches = 0;
  int   quiet_cycles = 0;
  res_t pending_controls [$];

  phfu_in_if  in_ch ();
  phfu_out_if res_ch ();

  pipeline_hazard_forward_unit_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] enc_r(input logic [4:0] rs, rt, rd, input logic [5:0] fn);
    enc_r = {OP_SPECIAL, rs, rt, rd, 5'd0, fn};
  endfunction

  function automatic logic [31:0] enc_i(input logic [5:0] op, input logic [4:0] rs, rt,
                                        input logic [15:0] imm);
    enc_i = {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] read_mask(input logic [31:0] w);
    logic [5:0] op;
    logic [5:0] fn;
    op = w[31:26];
    fn = w[5:0];
    read_mask = '0;
    if ((op == OP_SPECIAL && fn != FUNCT_JR && w != NOOP_WORD) || op == OP_SW ||
        op == OP_BEQ) begin
      if (op == OP_SPECIAL && (fn == FUNCT_SLL || fn == FUNCT_SRL)) begin
        read_mask[w[20:16]] = 1'b1;
      end else begin
        read_mask[w[25:21]] = 1'b1;
        read_mask[w[20:16]] = 1'b1;
      end
    end else if (op == OP_LW || (op == OP_SPECIAL && fn == FUNCT_JR)) begin
      read_mask[w[25:21]] = 1'b1;
    end
  endfunction

  // Bit 5 flags a register write, bits 4:0 hold the destination.
  function automatic logic [5:0] dest_of(input logic [31:0] w);
    dest_of = '0;
    if (w[31:26] == OP_SPECIAL && w[5:0] != FUNCT_JR && w != NOOP_WORD) begin
      dest_of = {1'b1, w[15:11]};
    end else if (w[31:26] == OP_LW || w[31:26] == OP_LUI) begin
      dest_of = {1'b1, w[20:16]};
    end
  endfunction

  function automatic logic [1:0] operand_source(input logic [31:0] reads, input logic [5:0] e_dst,
                                                input logic [5:0] m_dst, input logic [4:0] r);
    operand_source = SEL_REGFILE;
    if (reads[r] && e_dst[5] && e_dst[4:0] == r) begin
      operand_source = SEL_EXECUTE;
    end else if (reads[r] && m_dst[5] && m_dst[4:0] == r) begin
      operand_source = SEL_WRITEBACK;
    end
  endfunction

  function automatic res_t decide_controls(input logic [31:0] dec_w, exe_w, mem_w);
    logic [31:0] reads;
    logic [5:0]  e_dst;
    logic [5:0]  m_dst;
    logic        stall_ld;
    logic        stall_br;
    logic        jumping;
    logic        reg_jump;
    res_t        r;
    reads = read_mask(dec_w);
    e_dst = dest_of(exe_w);
    m_dst = dest_of(mem_w);
    stall_ld = (exe_w[31:26] == OP_LW || exe_w[31:26] == OP_LUI) && reads[e_dst[4:0]];
    stall_br = dec_w[31:26] == OP_BEQ || exe_w[31:26] == OP_BEQ;
    jumping = dec_w[31:26] == OP_J || dec_w[31:26] == OP_JAL;
    reg_jump = dec_w[31:26] == OP_SPECIAL && dec_w[5:0] == FUNCT_JR;
    r.load_use_stall = stall_ld;
    r.branch_stall = stall_br;
    r.first_source_select = stall_ld ? SEL_REGFILE :
                            operand_source(reads, e_dst, m_dst, dec_w[25:21]);
    r.second_source_select = stall_ld ? SEL_REGFILE :
                             operand_source(reads, e_dst, m_dst, dec_w[20:16]);
    if (stall_ld) begin
      r.fetch_action = FETCH_HOLD;
    end else if (stall_br || jumping || reg_jump) begin
      r.fetch_action = FETCH_BUBBLE;
    end else begin
      r.fetch_action = FETCH_NEXT;
    end
    if (exe_w[31:26] == OP_BEQ) begin
      r.pc_action = PC_BRANCH;
    end else if (stall_br || stall_ld) begin
      r.pc_action = PC_HOLD;
    end else if (jumping) begin
      r.pc_action = PC_JUMP;
    end else if (reg_jump) begin
      r.pc_action = PC_REGISTER;
    end else begin
      r.pc_action = PC_PLUS4;
    end
    r.jump_target = {dec_w[25:0], 2'b00};
    r.link_write = dec_w[31:26] == OP_JAL && !stall_br && !stall_ld;
    r.jump_register_index = dec_w[25:21];
    r.first_source_index = dec_w[25:21];
    r.second_source_index = dec_w[20:16];
    return r;
  endfunction

  // Small register numbers most of the time, so that stages often collide.
  function automatic logic [4:0] pick_reg();
    pick_reg = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    w = $urandom;
    rs = pick_reg();
    rt = pick_reg();
    rd = pick_reg();
    case ($urandom_range(0, 13))
      0: w = NOOP_WORD;
      1, 12: w = w;
      2, 3: w = {OP_SPECIAL, rs, rt, rd, w[10:0]};
      4: w = {OP_SPECIAL, rs, rt, rd, w[10:6], ($urandom_range(0, 1) ? FUNCT_SLL : FUNCT_SRL)};
      5: w = {OP_SPECIAL, rs, w[20:6], FUNCT_JR};
      6, 13: w = {OP_LW, rs, rt, w[15:0]};
      7: w = {OP_SW, rs, rt, w[15:0]};
      8: w = {OP_BEQ, rs, rt, w[15:0]};
      9: w = {OP_LUI, rs, rt, w[15:0]};
      10: w = {OP_J, w[25:0]};
      default: w = {OP_JAL, w[25:0]};
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("%0t: mismatch, %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [27:0] got, want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
    end
  endtask

  task automatic send_request(input logic [31:0] dec_w, exe_w, mem_w, input res_t want);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.decode_word <= dec_w;
    in_ch.execute_word <= exe_w;
    in_ch.memory_word <= mem_w;
    pending_controls.push_back(want);
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  always @(posedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n === 1'b1) begin
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        if (pending_controls.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = pending_controls.pop_front();
          check_field("load_use_stall", 28'(res_ch.load_use_stall),
                      28'(want.load_use_stall));
          check_field("branch_stall", 28'(res_ch.branch_stall), 28'(want.branch_stall));
          check_field("first_source_select", 28'(res_ch.first_source_select),
                      28'(want.first_source_select));
          check_field("second_source_select", 28'(res_ch.second_source_select),
                      28'(want.second_source_select));
          check_field("fetch_action", 28'(res_ch.fetch_action), 28'(want.fetch_action));
          check_field("pc_action", 28'(res_ch.pc_action), 28'(want.pc_action));
          check_field("jump_target", res_ch.jump_target, want.jump_target);
          check_field("link_write", 28'(res_ch.link_write), 28'(want.link_write));
          check_field("jump_register_index", 28'(res_ch.jump_register_index),
                      28'(want.jump_register_index));
          check_field("first_source_index", 28'(res_ch.first_source_index),
                      28'(want.first_source_index));
          check_field("second_source_index", 28'(res_ch.second_source_index),
                      28'(want.second_source_index));
        end
      end
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    stim_row_t   rows [$];
    logic [31:0] dec_w;
    logic [31:0] exe_w;
    logic [31:0] mem_w;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.decode_word = '0;
    in_ch.execute_word = '0;
    in_ch.memory_word = '0;
    res_ch.ready = 1'b0;

    rows.push_back('{NOOP_WORD, NOOP_WORD, NOOP_WORD, 1'b1,
                     res_t'{1'b0, 1'b0, SEL_REGFILE, SEL_REGFILE, FETCH_NEXT, PC_PLUS4,
                            28'h0, 1'b0, 5'd0, 5'd0, 5'd0}});
    rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                     res_t'{1'b0, 1'b0, SEL_REGFILE, SEL_REGFILE, FETCH_NEXT, PC_PLUS4,
                            28'hFFF_FFFC, 1'b0, 5'd31, 5'd31, 5'd31}});
    rows.push_back('{{OP_J, 26'h3FF_FFFF}, NOOP_WORD, NOOP_WORD, 1'b1,
                     res_t'{1'b0, 1'b0, SEL_REGFILE, SEL_REGFILE, FETCH_BUBBLE, PC_JUMP,
                            28'hFFF_FFFC, 1'b0, 5'd31, 5'd31, 5'd31}});
    rows.push_back('{{OP_JAL, 26'h0}, NOOP_WORD, NOOP_WORD, 1'b1,
                     res_t'{1'b0, 1'b0, SEL_REGFILE, SEL_REGFILE, FETCH_BUBBLE, PC_JUMP,
                            28'h0, 1'b1, 5'd0, 5'd0, 5'd0}});
    rows.push_back('{enc_r(1, 2, 3, FUNCT_ADD), enc_r(4, 5, 1, FUNCT_ADD),
                     enc_r(6, 7, 2, FUNCT_ADD), 1'b0, '0});
    rows.push_back('{enc_r(1, 2, 3, FUNCT_ADD), enc_r(4, 5, 2, FUNCT_ADD),
                     enc_r(6, 7, 2, FUNCT_ADD), 1'b0, '0});
    rows.push_back('{enc_r(1, 2, 3, FUNCT_ADD), enc_i(OP_LW, 4, 2, 16'h0010),
                     enc_r(6, 7, 1, FUNCT_ADD), 1'b0, '0});
    rows.push_back('{enc_i(OP_SW, 1, 5, 16'h8000), enc_i(OP_LUI, 0, 1, 16'hFFFF),
                     NOOP_WORD, 1'b0, '0});
    rows.push_back('{enc_r(1, 2, 3, FUNCT_ADD), enc_i(OP_LW, 1, 9, 16'h0),
                     enc_i(OP_LW, 0, 1, 16'h0), 1'b0, '0});
    rows.push_back('{enc_i(OP_BEQ, 1, 2, 16'hFFFF), enc_r(3, 4, 1, FUNCT_ADD),
                     enc_r(3, 4, 2, FUNCT_ADD), 1'b0, '0});
    rows.push_back('{{OP_JAL, 26'h155_5555}, enc_i(OP_BEQ, 1, 1, 16'h0), NOOP_WORD, 1'b0, '0});
    rows.push_back('{enc_r(5, 0, 0, FUNCT_JR), enc_i(OP_LW, 0, 5, 16'h0), NOOP_WORD, 1'b0, '0});
    rows.push_back('{enc_r(7, 0, 0, FUNCT_JR), enc_r(1, 2, 7, FUNCT_ADD),
                     enc_r(1, 2, 7, FUNCT_ADD), 1'b0, '0});
    rows.push_back('{enc_r(3, 4, 5, FUNCT_SLL), enc_r(0, 0, 3, FUNCT_ADD),
                     enc_i(OP_LUI, 0, 4, 16'h0), 1'b0, '0});
    rows.push_back('{enc_r(6, 6, 1, FUNCT_SRL), enc_r(2, 2, 6, FUNCT_ADD), NOOP_WORD, 1'b0, '0});
    rows.push_back('{enc_r(0, 0, 0, FUNCT_ADD), enc_r(1, 1, 0, FUNCT_ADD),
                     enc_i(OP_LW, 0, 0, 16'h0), 1'b0, '0});
    rows.push_back('{enc_i(OP_LW, 8, 9, 16'h7FFF), enc_r(0, 0, 9, FUNCT_ADD),
                     enc_i(OP_LUI, 0, 8, 16'h0), 1'b0, '0});
    rows.push_back('{enc_i(OP_UNUSED, 3, 4, 16'h0), enc_r(0, 0, 3, FUNCT_ADD),
                     enc_r(0, 0, 4, FUNCT_ADD), 1'b0, '0});
    rows.push_back('{enc_r(0, 0, 1, FUNCT_ADD), NOOP_WORD, NOOP_WORD, 1'b0, '0});
    rows.push_back('{enc_r(1, 2, 3, FUNCT_ADD), enc_r(1, 0, 0, FUNCT_JR),
                     enc_i(OP_SW, 0, 2, 16'h0), 1'b0, '0});
    rows.push_back('{enc_i(OP_BEQ, 1, 2, 16'h0), enc_i(OP_LW, 0, 1, 16'h0), NOOP_WORD, 1'b0, '0});
    rows.push_back('{enc_r(0, 0, 1, FUNCT_ADD), enc_i(OP_LUI, 0, 0, 16'h0), NOOP_WORD, 1'b0, '0});
    rows.push_back('{NOOP_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0});
    rows.push_back('{enc_r(4, 4, 2, FUNCT_ADD), enc_r(0, 1, 4, FUNCT_SLL),
                     {OP_J, 26'h2AA_AAAA}, 1'b0, '0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      send_request(rows[i].dec_w, rows[i].exe_w, rows[i].mem_w,
                   rows[i].typed ? rows[i].want :
                   decide_controls(rows[i].dec_w, rows[i].exe_w, rows[i].mem_w));
    end

    dec_w = NOOP_WORD;
    exe_w = NOOP_WORD;
    mem_w = NOOP_WORD;
    for (int ph = 0; ph < 4; ph++) begin
      in_ch.valid <= 1'b0;
      while (pending_controls.size() != 0) @(posedge clk);
      @(posedge clk);
      idle_pct = IDLE_PCT[ph];
      stall_pct = STALL_PCT[ph];
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Mostly let the words advance through the stages like a real instruction stream.
        if ($urandom_range(0, 4) != 0) begin
          mem_w = exe_w;
          exe_w = dec_w;
        end else begin
          exe_w = rand_word();
          mem_w = rand_word();
        end
        dec_w = rand_word();
        send_request(dec_w, exe_w, mem_w, decide_controls(dec_w, exe_w, mem_w));
      end
    end

    in_ch.valid <= 1'b0;
    while (pending_controls.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/phfu_pkg.sv
rtl/core/phfu_if.sv
rtl/core/phfu_decode.sv
rtl/core/pipeline_hazard_forward_unit_core.sv
dv/tb_pipeline_hazard_forward_unit_core.sv
